@@ rtl/core/generational_handle_table_assert.svh @@
// ----------------------------------------------------------------------------
// Generational handle table assertion macros
// Concurrent assertion wrappers clocked on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH

// Checked only while out of reset.
`define GHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("generational_handle_table: assertion failed");

// Checked at every edge, reset included.
`define GHT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("generational_handle_table: invariant broken");

`endif

@@ rtl/core/ght_pkg.sv @@
// ----------------------------------------------------------------------------
// ght_pkg
// Field widths, operation and status codes, and control struct for the table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned OWNER_W  = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FETCH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Side effects of one committed request
  typedef struct packed {
    logic ent_we;    // write the entry memory
    logic stk_push;  // push a freed slot
    logic stk_pop;   // reuse the top of the free stack
    logic issue;     // hand out a never-used slot
  } ctl_t;

endpackage

@@ rtl/core/ght_req_if.sv @@
// ----------------------------------------------------------------------------
// ght_req_if
// Request channel: valid/ready handshake with operation and handle fields.
// ----------------------------------------------------------------------------
interface ght_req_if;
  logic                        valid;
  logic                        ready;
  logic [ght_pkg::OP_W-1:0]    operation;
  logic [ght_pkg::SLOT_W-1:0]  slot_index;
  logic [ght_pkg::GEN_W-1:0]   generation_in;
  logic [ght_pkg::OWNER_W-1:0] owner_in;

  modport source (
    output valid, operation, slot_index, generation_in, owner_in,
    input  ready
  );
  modport sink (
    input  valid, operation, slot_index, generation_in, owner_in,
    output ready
  );
endinterface

@@ rtl/core/ght_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ght_rsp_if
// Response channel: valid/ready handshake with status and handle fields.
// ----------------------------------------------------------------------------
interface ght_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ght_pkg::STATUS_W-1:0] status;
  logic [ght_pkg::SLOT_W-1:0]   slot_out;
  logic [ght_pkg::GEN_W-1:0]    generation_out;
  logic [ght_pkg::OWNER_W-1:0]  owner_out;

  modport source (
    output valid, status, slot_out, generation_out, owner_out,
    input  ready
  );
  modport sink (
    input  valid, status, slot_out, generation_out, owner_out,
    output ready
  );
endinterface

@@ rtl/core/ght_ram.sv @@
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ght_exec.sv @@
// ----------------------------------------------------------------------------
// ght_exec
// Decides one request from the read entry and stack top; builds write-back.
// ----------------------------------------------------------------------------
module ght_exec #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned GEN_BITS   = 16,
  parameter int unsigned OWNER_BITS = 32,
  localparam int unsigned SIDX_W    = $clog2(SLOTS),
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1),
  localparam int unsigned ENT_W     = 1 + GEN_BITS + OWNER_BITS,
  localparam int unsigned STK_W     = SIDX_W + GEN_BITS
) (
  input  logic [ght_pkg::OP_W-1:0]     op_i,
  input  logic [ght_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ght_pkg::GEN_W-1:0]    gen_i,
  input  logic [OWNER_BITS-1:0]        owner_i,
  input  logic [ENT_W-1:0]             ent_rdata_i,
  input  logic [STK_W-1:0]             stk_rdata_i,
  input  logic [CNT_W-1:0]             free_count_i,
  input  logic [CNT_W-1:0]             issued_i,
  output ght_pkg::ctl_t                ctl_o,
  output logic [SIDX_W-1:0]            ent_waddr_o,
  output logic [ENT_W-1:0]             ent_wdata_o,
  output logic [STK_W-1:0]             stk_wdata_o,
  output logic [ght_pkg::STATUS_W-1:0] status_o,
  output logic [ght_pkg::SLOT_W-1:0]   slot_o,
  output logic [ght_pkg::GEN_W-1:0]    gen_o,
  output logic [ght_pkg::OWNER_W-1:0]  owner_o
);

  logic                  ent_occ;
  logic [GEN_BITS-1:0]   ent_gen;
  logic [OWNER_BITS-1:0] ent_owner;
  logic [GEN_BITS-1:0]   gen_next;
  logic [SIDX_W-1:0]     stk_slot;
  logic [GEN_BITS-1:0]   stk_gen;
  logic [SIDX_W-1:0]     slot_idx;
  logic                  slot_ok;
  ght_pkg::status_e      status;

  assign ent_occ   = ent_rdata_i[ENT_W-1];
  assign ent_gen   = ent_rdata_i[OWNER_BITS +: GEN_BITS];
  assign ent_owner = ent_rdata_i[OWNER_BITS-1:0];
  assign gen_next  = ent_gen + GEN_BITS'(1);
  assign stk_slot  = stk_rdata_i[GEN_BITS +: SIDX_W];
  assign stk_gen   = stk_rdata_i[GEN_BITS-1:0];
  assign slot_idx  = SIDX_W'(slot_i);

  // Slots at or above the issue count were never written: their entry reads are ignored
  assign slot_ok = (32'(slot_i) < SLOTS) && (32'(slot_i) < 32'(issued_i));

  assign stk_wdata_o = {slot_idx, gen_next};

  always_comb begin
    ctl_o       = '0;
    status      = ght_pkg::ST_OK;
    slot_o      = '0;
    gen_o       = '0;
    owner_o     = '0;
    ent_waddr_o = slot_idx;
    ent_wdata_o = {1'b0, gen_next, {OWNER_BITS{1'b0}}};
    unique case (ght_pkg::op_e'(op_i))
      ght_pkg::OP_ALLOC: begin
        if (free_count_i != '0) begin
          ctl_o.stk_pop = 1'b1;
          ctl_o.ent_we  = 1'b1;
          ent_waddr_o   = stk_slot;
          ent_wdata_o   = {1'b1, stk_gen, owner_i};
          slot_o        = ght_pkg::SLOT_W'(stk_slot);
          gen_o         = ght_pkg::GEN_W'(stk_gen);
        end else if (issued_i < CNT_W'(SLOTS)) begin
          ctl_o.issue  = 1'b1;
          ctl_o.ent_we = 1'b1;
          ent_waddr_o  = issued_i[SIDX_W-1:0];
          ent_wdata_o  = {1'b1, {GEN_BITS{1'b0}}, owner_i};
          slot_o       = ght_pkg::SLOT_W'(issued_i[SIDX_W-1:0]);
        end else begin
          status = ght_pkg::ST_FULL;
        end
      end
      ght_pkg::OP_FREE: begin
        if (!slot_ok || !ent_occ || free_count_i >= CNT_W'(SLOTS)) begin
          status = ght_pkg::ST_EMPTY;
        end else begin
          ctl_o.ent_we   = 1'b1;
          ctl_o.stk_push = 1'b1;
        end
      end
      ght_pkg::OP_FETCH: begin
        if (!slot_ok || !ent_occ || ent_gen != GEN_BITS'(gen_i)) begin
          status = ght_pkg::ST_STALE;
        end else begin
          owner_o = ght_pkg::OWNER_W'(ent_owner);
        end
      end
      default: begin
        status = ght_pkg::ST_STALE;
      end
    endcase
  end

  assign status_o = status;

endmodule

@@ rtl/core/generational_handle_table.sv @@
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map handing out slot-plus-generation handles, backed by two RAMs.
// ----------------------------------------------------------------------------
// Each request passes through IDLE and EXEC: the accept edge launches the
// reads of the slot entry and of the free-stack top, and the commit edge in
// EXEC decides the request, writes the entry and stack back and loads the
// response register, in one read-modify-write pass over the entry RAM. Commit
// waits in EXEC while a full response register is not drained.
// Only one request is in flight, so reads never race the write-back. There is
// no clearing pass after reset: the issued-slot count marks which entries have
// ever been written, and a slot at or above it reads as empty, generation 0.
// Free pushes {slot, new generation} so an allocate that reuses a slot needs
// no second entry read. Status: 0 ok, 1 full, 2 stale or unknown handle,
// 3 free of an empty slot.
// ----------------------------------------------------------------------------
`include "generational_handle_table_assert.svh"

module generational_handle_table #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned GEN_BITS   = 16,
  parameter int unsigned OWNER_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ght_req_if.sink  req_i,
  ght_rsp_if.source rsp_o
);

  localparam int unsigned SIDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned ENT_W  = 1 + GEN_BITS + OWNER_BITS;
  localparam int unsigned STK_W  = SIDX_W + GEN_BITS;

  // Two-state sequencer: IDLE takes a request, EXEC commits it
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Table bookkeeping
  logic [CNT_W-1:0] free_count_q, free_count_d;
  logic [CNT_W-1:0] issued_q, issued_d;

  // Latched request
  logic [ght_pkg::OP_W-1:0]   op_q;
  logic [ght_pkg::SLOT_W-1:0] slot_q;
  logic [ght_pkg::GEN_W-1:0]  gen_q;
  logic [OWNER_BITS-1:0]      owner_q;

  // Response register
  logic                         rsp_valid_q, rsp_valid_d;
  logic [ght_pkg::STATUS_W-1:0] rsp_status_q;
  logic [ght_pkg::SLOT_W-1:0]   rsp_slot_q;
  logic [ght_pkg::GEN_W-1:0]    rsp_gen_q;
  logic [ght_pkg::OWNER_W-1:0]  rsp_owner_q;

  logic accept;
  logic commit;

  // RAM ports
  logic [ENT_W-1:0]  ent_rdata, ent_wdata;
  logic [SIDX_W-1:0] ent_waddr;
  logic [STK_W-1:0]  stk_rdata, stk_wdata;

  // Decision outputs
  ght_pkg::ctl_t                ctl;
  logic [ght_pkg::STATUS_W-1:0] ex_status;
  logic [ght_pkg::SLOT_W-1:0]   ex_slot;
  logic [ght_pkg::GEN_W-1:0]    ex_gen;
  logic [ght_pkg::OWNER_W-1:0]  ex_owner;

  // Ready only between requests; a waiting response does not block intake
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Commit once the response register is free or being drained this edge
  assign commit = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);

  // Entry RAM: {occupied, generation, owner} per slot
  ght_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (commit && ctl.ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (accept),
    .raddr_i (SIDX_W'(req_i.slot_index)),
    .rdata_o (ent_rdata)
  );

  // Free stack RAM: {slot, generation}, top at free_count - 1
  ght_ram #(
    .WIDTH (STK_W),
    .DEPTH (SLOTS)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (commit && ctl.stk_push),
    .waddr_i (free_count_q[SIDX_W-1:0]),
    .wdata_i (stk_wdata),
    .re_i    (accept),
    .raddr_i (SIDX_W'(free_count_q - CNT_W'(1))),
    .rdata_o (stk_rdata)
  );

  ght_exec #(
    .SLOTS      (SLOTS),
    .GEN_BITS   (GEN_BITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_exec (
    .op_i         (op_q),
    .slot_i       (slot_q),
    .gen_i        (gen_q),
    .owner_i      (owner_q),
    .ent_rdata_i  (ent_rdata),
    .stk_rdata_i  (stk_rdata),
    .free_count_i (free_count_q),
    .issued_i     (issued_q),
    .ctl_o        (ctl),
    .ent_waddr_o  (ent_waddr),
    .ent_wdata_o  (ent_wdata),
    .stk_wdata_o  (stk_wdata),
    .status_o     (ex_status),
    .slot_o       (ex_slot),
    .gen_o        (ex_gen),
    .owner_o      (ex_owner)
  );

  // Next-state logic
  always_comb begin
    state_d      = state_q;
    free_count_d = free_count_q;
    issued_d     = issued_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d     = S_IDLE;
          rsp_valid_d = 1'b1;
          if (ctl.stk_pop) begin
            free_count_d = free_count_q - CNT_W'(1);
          end else if (ctl.stk_push) begin
            free_count_d = free_count_q + CNT_W'(1);
          end
          if (ctl.issue) begin
            issued_d = issued_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_count_q <= '0;
      issued_q     <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_count_q <= free_count_d;
      issued_q     <= issued_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  // Request latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_i.operation;
      slot_q  <= req_i.slot_index;
      gen_q   <= req_i.generation_in;
      owner_q <= OWNER_BITS'(req_i.owner_in);
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_status_q <= ex_status;
      rsp_slot_q   <= ex_slot;
      rsp_gen_q    <= ex_gen;
      rsp_owner_q  <= ex_owner;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.slot_out       = rsp_slot_q;
  assign rsp_o.generation_out = rsp_gen_q;
  assign rsp_o.owner_out      = rsp_owner_q;

  // Every slot on the free stack has been issued
  `GHT_ASSERT_ALWAYS(a_free_le_issued, free_count_q <= issued_q)
  // A committed request has at most one source of its slot or one push
  `GHT_ASSERT(a_one_stack_op, commit |-> $onehot0({ctl.stk_pop, ctl.stk_push, ctl.issue}))
  // A commit always leaves a response waiting
  `GHT_ASSERT(a_commit_rsp, commit |=> rsp_valid_q)
  // The issue count only grows
  `GHT_ASSERT(a_issued_mono, issued_q >= $past(issued_q))

endmodule

@@ sim/ght_handle_checker.sv @@
// ----------------------------------------------------------------------------
// Handle table checker
// Watches the request and response channels, predicts each response from a
// private copy of the table state and compares it against the block output.
// ----------------------------------------------------------------------------
module ght_handle_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ght_req_if   req_mon,
  ght_rsp_if   rsp_mon,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_SLOTS = 1 << ght_pkg::SLOT_W;

  typedef struct packed {
    ght_pkg::status_e                status;
    logic [ght_pkg::SLOT_W-1:0]  slot;
    logic [ght_pkg::GEN_W-1:0]   gen;
    logic [ght_pkg::OWNER_W-1:0] owner;
  } table_rsp_t;

  logic [ght_pkg::OWNER_W-1:0] owner_mem  [NUM_SLOTS];
  logic [ght_pkg::GEN_W-1:0]   gen_mem    [NUM_SLOTS];
  logic                        in_use     [NUM_SLOTS];
  logic [ght_pkg::SLOT_W-1:0]  free_stack [NUM_SLOTS];
  int unsigned                 free_depth;
  int unsigned                 issued_count;
  table_rsp_t                  expected_rsps [$];
  int                          mismatch_count;

  assign errors_o = mismatch_count;

  // Applies one request to the shadow table and returns its response.
  function automatic table_rsp_t predict_table_op(ght_pkg::op_e op,
                                                  logic [ght_pkg::SLOT_W-1:0] slot,
                                                  logic [ght_pkg::GEN_W-1:0] gen,
                                                  logic [ght_pkg::OWNER_W-1:0] owner);
    table_rsp_t  rsp;
    int unsigned pick;
    rsp        = '0;
    rsp.status = ght_pkg::ST_OK;
    pick       = 0;
    case (op)
      ght_pkg::OP_ALLOC: begin
        // LIFO reuse first, then a fresh slot
        if (free_depth > 0) begin
          free_depth--;
          pick = 32'(free_stack[free_depth]);
        end else if (issued_count < NUM_SLOTS) begin
          pick = issued_count;
          issued_count++;
        end else begin
          rsp.status = ght_pkg::ST_FULL;
        end
        if (rsp.status == ght_pkg::ST_OK) begin
          owner_mem[pick] = owner;
          in_use[pick]    = 1'b1;
          rsp.slot        = pick[ght_pkg::SLOT_W-1:0];
          rsp.gen         = gen_mem[pick];
        end
      end
      ght_pkg::OP_FREE: begin
        // no generation check on free
        if (slot >= issued_count || !in_use[slot] || free_depth >= NUM_SLOTS) begin
          rsp.status = ght_pkg::ST_EMPTY;
        end else begin
          in_use[slot]           = 1'b0;
          owner_mem[slot]        = '0;
          gen_mem[slot]          = gen_mem[slot] + ght_pkg::GEN_W'(1);
          free_stack[free_depth] = slot;
          free_depth++;
        end
      end
      ght_pkg::OP_FETCH: begin
        if (slot >= issued_count || !in_use[slot] || gen_mem[slot] != gen) begin
          rsp.status = ght_pkg::ST_STALE;
        end else begin
          rsp.owner = owner_mem[slot];
        end
      end
      default: begin
        rsp.status = ght_pkg::ST_STALE;
      end
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        in_use[i]  = 1'b0;
        gen_mem[i] = '0;
      end
      free_depth     = 0;
      issued_count   = 0;
      mismatch_count = 0;
      expected_rsps.delete();
    end else begin
      // response side first: its request was accepted on an earlier edge
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("unexpected response st=%0d slot=%0d gen=%0d owner=%h",
                                    rsp_mon.status, rsp_mon.slot_out,
                                    rsp_mon.generation_out, rsp_mon.owner_out));
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_mon.status !== want.status || rsp_mon.slot_out !== want.slot ||
              rsp_mon.generation_out !== want.gen || rsp_mon.owner_out !== want.owner) begin
            report_mismatch($sformatf(
              "want st=%0d slot=%0d gen=%0d owner=%h, got st=%0d slot=%0d gen=%0d owner=%h",
              want.status, want.slot, want.gen, want.owner,
              rsp_mon.status, rsp_mon.slot_out, rsp_mon.generation_out,
              rsp_mon.owner_out));
          end
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        expected_rsps.insert(expected_rsps.size(),
                             predict_table_op(ght_pkg::op_e'(req_mon.operation),
                                              req_mon.slot_index,
                                              req_mon.generation_in,
                                              req_mon.owner_in));
      end
    end
    pending_o = expected_rsps.size();
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Handle table testbench
// Drives allocate, free and fetch requests into the handle table with random
// gaps and response back-pressure; a checker beside the block predicts and
// compares every response, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 1800;
  // ~1850 requests plus two long hold-offs, with a wide margin
  localparam int CYCLE_LIMIT = 400000;

  // Handle as seen by a user of the table
  typedef struct {
    logic [ght_pkg::SLOT_W-1:0] slot;
    logic [ght_pkg::GEN_W-1:0]  gen;
  } handle_t;

  logic clk_i;
  logic rst_ni;

  ght_req_if req_ch ();
  ght_rsp_if rsp_ch ();

  int           errors;
  int           outstanding;
  int           cycle_count = 0;
  handle_t      live_handles [$];  // handles believed live, used to aim frees and fetches
  ght_pkg::op_e sent_ops     [$];  // ops in flight, matched to responses in order
  bit           sender_steady = 1'b0;

  generational_handle_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  ght_handle_checker checker_inst (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_mon   (req_ch),
    .rsp_mon   (rsp_ch),
    .errors_o  (errors),
    .pending_o (outstanding)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: the run must end well before this
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Idle length: mostly short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(9, 30);
  endfunction

  // Learn handles from allocate responses so that later frees and fetches
  // can target live slots with the right generation.
  always @(posedge clk_i) begin : track_handles
    ght_pkg::op_e op;
    handle_t      h;
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1 && sent_ops.size() > 0) begin
      op = sent_ops.pop_front();
      if (op == ght_pkg::OP_ALLOC && ght_pkg::status_e'(rsp_ch.status) == ght_pkg::ST_OK) begin
        h.slot = rsp_ch.slot_out;
        h.gen  = rsp_ch.generation_out;
        live_handles.insert(live_handles.size(), h);
      end
    end
  end

  // Offer one request, hold it until accepted, then maybe idle.
  task automatic send_req(ght_pkg::op_e op, logic [ght_pkg::SLOT_W-1:0] slot,
                          logic [ght_pkg::GEN_W-1:0] gen,
                          logic [ght_pkg::OWNER_W-1:0] owner);
    int gap;
    int idx;
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.slot_index    <= slot;
    req_ch.generation_in <= gen;
    req_ch.owner_in      <= owner;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    sent_ops.insert(sent_ops.size(), op);
    // any free retires that slot's handle, whatever the outcome
    if (op == ght_pkg::OP_FREE) begin
      idx = -1;
      foreach (live_handles[i]) if (live_handles[i].slot == slot) idx = i;
      if (idx >= 0) live_handles.delete(idx);
    end
    gap = 0;
    if (!sender_steady && $urandom_range(0, 2) == 0) gap = idle_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Response drain: random stalls, calm stretches, and two long hold-offs
  // that back the block up while the sender keeps offering requests.
  initial begin : rsp_drain
    int stall_left;
    int cyc;
    bit steady;
    stall_left = 0;
    cyc        = 0;
    steady     = 1'b0;
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 250 == 0) steady = ($urandom_range(0, 2) == 0);
      if (cyc == 1500 || cyc == 6000) begin
        stall_left = 400;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
        stall_left = idle_gap();
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int                        seg_left;
    int                        alloc_pct;
    int                        r;
    int                        k;
    int                        b;
    logic [ght_pkg::GEN_W-1:0] g;

    req_ch.valid         <= 1'b0;
    req_ch.operation     <= ght_pkg::OP_NONE;
    req_ch.slot_index    <= '0;
    req_ch.generation_in <= '0;
    req_ch.owner_in      <= '0;
    rst_ni               <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed: empty table, extremes, reuse order ----
    send_req(ght_pkg::OP_FETCH, 8'd0,   16'd0,    32'd0);         // never issued -> stale
    send_req(ght_pkg::OP_FREE,  8'd0,   16'd0,    32'd0);         // free of empty slot
    send_req(ght_pkg::OP_FREE,  8'hFF,  16'hFFFF, 32'hFFFF_FFFF); // top slot, never issued
    send_req(ght_pkg::OP_NONE,  8'hFF,  16'hFFFF, 32'hFFFF_FFFF); // unknown op, all ones
    send_req(ght_pkg::OP_ALLOC, 8'd0,   16'd0,    32'd0);         // slot 0 gen 0, owner zero
    send_req(ght_pkg::OP_ALLOC, 8'hFF,  16'hFFFF, 32'hFFFF_FFFF); // slot 1, owner all ones
    send_req(ght_pkg::OP_FETCH, 8'd1,   16'd0,    32'd0);         // hit
    send_req(ght_pkg::OP_FETCH, 8'd1,   16'hFFFF, 32'd0);         // wrong generation
    send_req(ght_pkg::OP_FETCH, 8'd0,   16'd0,    32'hFFFF_FFFF); // hit, owner zero
    send_req(ght_pkg::OP_FREE,  8'd0,   16'd0,    32'd0);         // ok, gen -> 1
    send_req(ght_pkg::OP_FREE,  8'd0,   16'd0,    32'd0);         // double free
    send_req(ght_pkg::OP_FETCH, 8'd0,   16'd0,    32'd0);         // unoccupied, old gen
    send_req(ght_pkg::OP_FETCH, 8'd0,   16'd1,    32'd0);         // unoccupied, current gen
    send_req(ght_pkg::OP_ALLOC, 8'd0,   16'd0,    32'hA5A5_A5A5); // reuses slot 0 gen 1
    send_req(ght_pkg::OP_FETCH, 8'd0,   16'd1,    32'd0);         // hit
    send_req(ght_pkg::OP_FREE,  8'd1,   16'd0,    32'd0);
    send_req(ght_pkg::OP_FREE,  8'd0,   16'd0,    32'd0);         // stack now 1,0
    send_req(ght_pkg::OP_ALLOC, 8'd0,   16'd0,    32'h5A5A_5A5A); // LIFO: slot 0 gen 2
    send_req(ght_pkg::OP_ALLOC, 8'd0,   16'd0,    32'h0000_0001); // slot 1 gen 1
    send_req(ght_pkg::OP_ALLOC, 8'd0,   16'd0,    32'h8000_0000); // fresh slot 2
    send_req(ght_pkg::OP_FETCH, 8'd200, 16'd0,    32'd0);         // beyond issued
    send_req(ght_pkg::OP_FREE,  8'd2,   16'hFFFF, 32'd0);         // free ignores generation
    send_req(ght_pkg::OP_NONE,  8'd0,   16'd0,    32'd0);         // unknown op, all zero

    // ---- random: segments with varying allocate pressure ----
    // The first segment is allocate-heavy so the table fills and reports full.
    seg_left  = 320;
    alloc_pct = 92;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 200);
        case ($urandom_range(0, 2))
          0:       alloc_pct = 85;
          1:       alloc_pct = 50;
          default: alloc_pct = 20;
        endcase
      end
      seg_left--;
      if (n % 100 == 0) sender_steady = ($urandom_range(0, 3) == 0);

      r = $urandom_range(0, 99);
      k = (live_handles.size() > 0) ? $urandom_range(0, live_handles.size() - 1) : 0;
      if (r < alloc_pct) begin
        send_req(ght_pkg::OP_ALLOC, ght_pkg::SLOT_W'($urandom_range(0, 255)),
                 ght_pkg::GEN_W'($urandom_range(0, 65535)), $urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40 && live_handles.size() > 0) begin
          send_req(ght_pkg::OP_FREE, live_handles[k].slot,
                   ght_pkg::GEN_W'($urandom_range(0, 65535)), $urandom);
        end else if (r < 75 && live_handles.size() > 0) begin
          g = live_handles[k].gen;
          // occasionally a near-miss generation
          if ($urandom_range(0, 9) == 0) begin
            b    = $urandom_range(0, ght_pkg::GEN_W - 1);
            g[b] = ~g[b];
          end
          send_req(ght_pkg::OP_FETCH, live_handles[k].slot, g, $urandom);
        end else if (r < 86) begin
          send_req(ght_pkg::OP_FETCH, ght_pkg::SLOT_W'($urandom_range(0, 255)),
                   ght_pkg::GEN_W'($urandom_range(0, 65535)), $urandom);
        end else if (r < 95) begin
          send_req(ght_pkg::OP_FREE, ght_pkg::SLOT_W'($urandom_range(0, 255)),
                   ght_pkg::GEN_W'($urandom_range(0, 65535)), $urandom);
        end else begin
          send_req(ght_pkg::OP_NONE, ght_pkg::SLOT_W'($urandom_range(0, 255)),
                   ght_pkg::GEN_W'($urandom_range(0, 65535)), $urandom);
        end
      end
    end

    // ---- drain and verdict ----
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
